// ----- rtl/tsrr_pkg.sv -----
// Shared constants of the round-robin thread slot scheduler.
`default_nettype none

package tsrr_pkg;

  // Default sizes
  localparam int DefSlots   = 8;
  localparam int DefIdBits  = 16;
  localparam int DefPtrBits = 32;

  // Field widths fixed by the transfer format
  localparam int ActionBits = 2;
  localparam int StatusBits = 2;

  // Request codes carried in the slave-side tuser
  localparam logic [ActionBits-1:0] ActCreate = 2'd0;
  localparam logic [ActionBits-1:0] ActYield  = 2'd1;
  localparam logic [ActionBits-1:0] ActExit   = 2'd2;

  // Result status codes
  localparam logic [StatusBits-1:0] StatOk   = 2'd0;
  localparam logic [StatusBits-1:0] StatFull = 2'd1;
  localparam logic [StatusBits-1:0] StatIdle = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/thread_slot_round_robin_scheduler.sv -----
// Round-robin thread slot scheduler: slot table in memories, scan and result stage.
// Sequence: create goes from input transfer to the result step; yield and exit go through
//   accept, save or free the running slot, pick and memory read, and result.
// Throughput: one request in flight; the next is taken as soon as the sequencer is back
//   in idle, while the previous result may still wait in the output register.
// Reset: all slots free, nothing running, id counter zero; the id and context memories
//   are not cleared, a slot valid bit per entry masks them.
`default_nettype none

module thread_slot_round_robin_scheduler #(
  parameter int SLOTS    = tsrr_pkg::DefSlots,
  parameter int ID_BITS  = tsrr_pkg::DefIdBits,
  parameter int PTR_BITS = tsrr_pkg::DefPtrBits,
  localparam int SlotBits = $clog2(SLOTS),
  localparam int InDataW  = ((PTR_BITS + 7) / 8) * 8,
  localparam int OutDataW =
    ((tsrr_pkg::StatusBits + SlotBits + ID_BITS + PTR_BITS + 7) / 8) * 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Request stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [InDataW-1:0]              s_axis_tdata,  // context_req
  input  wire logic [tsrr_pkg::ActionBits-1:0] s_axis_tuser,  // action
  // Result stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [OutDataW-1:0]                  m_axis_tdata   // status, slot, thread_id,
                                                              // next_context
);

  import tsrr_pkg::*;

  // Sequencer states
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StExec = 3'd1;
  localparam logic [2:0] StSave = 3'd2;
  localparam logic [2:0] StPick = 3'd3;
  localparam logic [2:0] StResp = 3'd4;

  localparam logic [ID_BITS-1:0]  IdMax    = {ID_BITS{1'b1}};
  localparam logic [SlotBits-1:0] LastSlot = SlotBits'(SLOTS - 1);

  logic [2:0]            state_q, state_d;
  logic [ActionBits-1:0] act_q;
  logic [PTR_BITS-1:0]   ctx_q;
  logic                  run_valid_q, run_valid_d;
  logic [SlotBits-1:0]   run_idx_q, run_idx_d;
  logic [SLOTS-1:0]      slot_valid_q, slot_valid_d;
  logic [ID_BITS-1:0]    id_cnt_q, id_cnt_d;
  logic [SlotBits-1:0]   pick_q;
  logic                  found_q;
  logic                  out_valid_q, out_valid_d;
  logic [OutDataW-1:0]   out_data_q, out_data_d;

  logic                  in_xfer;
  logic                  out_free;
  logic                  free_found;
  logic [SlotBits-1:0]   free_idx;
  logic [ID_BITS-1:0]    id_next;
  logic [SlotBits-1:0]   rr_start;
  logic [2*SLOTS-1:0]    rr_rot;
  logic                  rr_found;
  logic [SlotBits-1:0]   rr_pos;
  logic [SlotBits:0]     rr_sum;
  logic [SlotBits-1:0]   rr_idx;

  // Memory ports
  logic [ID_BITS-1:0]    id_mem  [SLOTS];
  logic [PTR_BITS-1:0]   ctx_mem [SLOTS];
  logic                  id_we, ctx_we, mem_re;
  logic [SlotBits-1:0]   ctx_wa;
  logic [PTR_BITS-1:0]   ctx_wd;
  logic [ID_BITS-1:0]    id_rd_q;
  logic [PTR_BITS-1:0]   ctx_rd_q;

  assign s_axis_tready = (state_q == StIdle);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Find the lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = SlotBits'(i);
      end
    end
  end

  // Advance the id counter, skipping zero on wrap
  assign id_next = (id_cnt_q == IdMax) ? ID_BITS'(1) : id_cnt_q + ID_BITS'(1);

  // Round-robin search starting after the running slot
  always_comb begin
    if (!run_valid_q || run_idx_q == LastSlot) begin
      rr_start = '0;
    end else begin
      rr_start = run_idx_q + SlotBits'(1);
    end
    rr_rot   = {slot_valid_q, slot_valid_q} >> rr_start;
    rr_found = 1'b0;
    rr_pos   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (rr_rot[i]) begin
        rr_found = 1'b1;
        rr_pos   = SlotBits'(i);
      end
    end
    rr_sum = {1'b0, rr_start} + {1'b0, rr_pos};
    if (rr_sum >= (SlotBits + 1)'(SLOTS)) begin
      rr_sum = rr_sum - (SlotBits + 1)'(SLOTS);
    end
    rr_idx = rr_sum[SlotBits-1:0];
  end

  // Sequencer and table updates
  always_comb begin
    state_d      = state_q;
    run_valid_d  = run_valid_q;
    run_idx_d    = run_idx_q;
    slot_valid_d = slot_valid_q;
    id_cnt_d     = id_cnt_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_data_d   = out_data_q;
    id_we        = 1'b0;
    ctx_we       = 1'b0;
    ctx_wa       = free_idx;
    ctx_wd       = ctx_q;
    mem_re       = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (s_axis_tuser == ActCreate) begin
            state_d = StExec;
          end else if (s_axis_tuser == ActYield || s_axis_tuser == ActExit) begin
            state_d = StSave;
          end
        end
      end
      StExec: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
          if (free_found) begin
            id_we                  = 1'b1;
            ctx_we                 = 1'b1;
            slot_valid_d[free_idx] = 1'b1;
            id_cnt_d               = id_next;
            out_data_d = OutDataW'({{PTR_BITS{1'b0}}, id_next, free_idx, StatOk});
          end else begin
            out_data_d = OutDataW'({{PTR_BITS{1'b0}}, {ID_BITS{1'b0}},
                                    {SlotBits{1'b0}}, StatFull});
          end
        end
      end
      StSave: begin
        // Save the context on yield, free the slot on exit
        ctx_wa  = run_idx_q;
        state_d = StPick;
        if (run_valid_q) begin
          if (act_q == ActYield) begin
            ctx_we = 1'b1;
          end else begin
            slot_valid_d[run_idx_q] = 1'b0;
          end
        end
      end
      StPick: begin
        mem_re  = 1'b1;
        state_d = StResp;
      end
      StResp: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
          if (found_q) begin
            run_valid_d = 1'b1;
            run_idx_d   = pick_q;
            out_data_d  = OutDataW'({ctx_rd_q, id_rd_q, pick_q, StatOk});
          end else begin
            run_valid_d = 1'b0;
            run_idx_d   = '0;
            out_data_d  = OutDataW'({{PTR_BITS{1'b0}}, {ID_BITS{1'b0}},
                                     {SlotBits{1'b0}}, StatIdle});
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      run_valid_q  <= 1'b0;
      run_idx_q    <= '0;
      slot_valid_q <= '0;
      id_cnt_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      run_valid_q  <= run_valid_d;
      run_idx_q    <= run_idx_d;
      slot_valid_q <= slot_valid_d;
      id_cnt_q     <= id_cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      act_q <= s_axis_tuser;
      ctx_q <= s_axis_tdata[PTR_BITS-1:0];
    end
    if (state_q == StPick) begin
      pick_q  <= rr_idx;
      found_q <= rr_found;
    end
    out_data_q <= out_data_d;
  end

  // Thread id memory
  always_ff @(posedge clk_i) begin
    if (id_we) begin
      id_mem[free_idx] <= id_next;
    end
    if (mem_re) begin
      id_rd_q <= id_mem[rr_idx];
    end
  end

  // Context memory
  always_ff @(posedge clk_i) begin
    if (ctx_we) begin
      ctx_mem[ctx_wa] <= ctx_wd;
    end
    if (mem_re) begin
      ctx_rd_q <= ctx_mem[rr_idx];
    end
  end

  // Between requests the running slot is always an occupied one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle && run_valid_q) |-> slot_valid_q[run_idx_q])
    else $error("running slot is not occupied");

  // A good result always names a live thread, a failed one never does
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ((m_axis_tdata[StatusBits-1:0] == StatOk) ==
       (m_axis_tdata[StatusBits+SlotBits+ID_BITS-1:StatusBits+SlotBits] != '0)))
    else $error("thread id does not match status");

  // The id counter never returns to zero once it has started
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (id_cnt_q != '0) |=> (id_cnt_q != '0))
    else $error("id counter wrapped to zero");

  // The table changes only while a request is being worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle || state_q == StPick || state_q == StResp) |=>
      (slot_valid_q == $past(slot_valid_q)))
    else $error("slot table changed outside an update step");

endmodule

`default_nettype wire

// ----- verif/tb_thread_slot_round_robin_scheduler.sv -----
// Self-checking testbench for the round-robin thread slot scheduler: directed table, random mix.
module tb_thread_slot_round_robin_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import tsrr_pkg::*;

  localparam int Slots   = DefSlots;
  localparam int IdBits  = DefIdBits;
  localparam int PtrBits = DefPtrBits;
  localparam int SlotW   = $clog2(Slots);
  localparam int InW     = ((PtrBits + 7) / 8) * 8;
  localparam int ResW    = StatusBits + SlotW + IdBits + PtrBits;
  localparam int OutW    = ((ResW + 7) / 8) * 8;

  // Action code the block has no use for
  localparam logic [ActionBits-1:0] ActUnused = 2'd3;
  localparam logic [IdBits-1:0]     IdMax     = '1;
  localparam int RandItems = 1515;
  localparam int HoldCycles = 300;

  // One result transfer, status in the lowest bits
  typedef struct packed {
    logic [PtrBits-1:0]    next_context;
    logic [IdBits-1:0]     thread_id;
    logic [SlotW-1:0]      slot;
    logic [StatusBits-1:0] status;
  } grant_t;

  typedef struct packed {
    logic [ActionBits-1:0] action;
    logic [PtrBits-1:0]    ctx;
    logic                  typed;
    grant_t                want;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [InW-1:0]        s_axis_tdata;   // context_req
  logic [ActionBits-1:0] s_axis_tuser;   // action
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OutW-1:0]       m_axis_tdata;   // status, slot, thread_id, next_context

  // Shadow of the slot table and scheduler state
  logic [IdBits-1:0]  slot_tid [Slots];
  logic [PtrBits-1:0] slot_ptr [Slots];
  logic [IdBits-1:0]  last_tid;
  bit                 running;
  int                 run_at;

  grant_t owed_grants [$];
  int     bad_fields;
  bit     tx_idle_en;
  bit     rx_idle_en;
  bit     long_hold_req;

  thread_slot_round_robin_scheduler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic grant_t mk_grant(logic [StatusBits-1:0] st, int sl, int tid,
                                      logic [PtrBits-1:0] nc);
    grant_t g;
    g.status       = st;
    g.slot         = sl[SlotW-1:0];
    g.thread_id    = tid[IdBits-1:0];
    g.next_context = nc;
    return g;
  endfunction

  // Scan round-robin after the running slot, ending on the running slot itself
  function automatic grant_t pick_next_thread();
    int first;
    int idx;
    first = running ? (run_at + 1) % Slots : 0;
    for (int k = 0; k < Slots; k++) begin
      idx = (first + k) % Slots;
      if (slot_tid[idx] != '0) begin
        running = 1'b1;
        run_at  = idx;
        return mk_grant(StatOk, idx, slot_tid[idx], slot_ptr[idx]);
      end
    end
    running = 1'b0;
    run_at  = 0;
    return mk_grant(StatIdle, 0, 0, '0);
  endfunction

  // Update the shadow state for one request; return 1 when a result is due
  function automatic bit apply_request(logic [ActionBits-1:0] act, logic [PtrBits-1:0] ctx,
                                       output grant_t g);
    g = '0;
    case (act)
      ActCreate: begin
        for (int k = 0; k < Slots; k++) begin
          if (slot_tid[k] == '0) begin
            last_tid    = (last_tid == IdMax) ? IdBits'(1) : last_tid + 1'b1;
            slot_tid[k] = last_tid;
            slot_ptr[k] = ctx;
            g = mk_grant(StatOk, k, last_tid, '0);
            return 1'b1;
          end
        end
        g = mk_grant(StatFull, 0, 0, '0);
        return 1'b1;
      end
      ActYield: begin
        if (running) slot_ptr[run_at] = ctx;
        g = pick_next_thread();
        return 1'b1;
      end
      ActExit: begin
        if (running) slot_tid[run_at] = '0;
        g = pick_next_thread();
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Offer one request, hold it until the transfer, then log what it owes
  task automatic send_request(logic [ActionBits-1:0] act, logic [PtrBits-1:0] ctx,
                              logic typed, grant_t want);
    grant_t g;
    bit     due;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= InW'(ctx);
    do @(posedge clk_i); while (!s_axis_tready);
    due = apply_request(act, ctx, g);
    if (due) owed_grants.push_back(typed ? want : g);
  endtask

  task automatic maybe_gap();
    if (tx_idle_en && !long_hold_req && $urandom_range(0, 99) < 20) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task automatic check_field(string what, logic [PtrBits-1:0] want, logic [PtrBits-1:0] got);
    if (want !== got) begin
      bad_fields++;
      $display("%0t ns: %s expected %h got %h", $time, what, want, got);
    end
  endtask

  // Stimulus
  initial begin
    dir_row_t rows [25];
    int       n_done;
    int       create_pct;
    int       pick;
    bit       hold_done;
    bit       pause_done;
    logic [ActionBits-1:0] act;
    logic [PtrBits-1:0]    ctx;

    rows = '{
      '{ActYield,  32'h0000_0000, 1'b1, mk_grant(StatIdle, 0, 0, '0)},
      '{ActExit,   32'h1111_1111, 1'b1, mk_grant(StatIdle, 0, 0, '0)},
      '{ActUnused, 32'h1234_5678, 1'b0, grant_t'('0)},
      '{ActCreate, 32'hFFFF_FFFF, 1'b1, mk_grant(StatOk, 0, 1, '0)},
      '{ActCreate, 32'h0000_0000, 1'b1, mk_grant(StatOk, 1, 2, '0)},
      '{ActCreate, 32'hA5A5_A5A5, 1'b1, mk_grant(StatOk, 2, 3, '0)},
      '{ActCreate, 32'h5A5A_5A5A, 1'b1, mk_grant(StatOk, 3, 4, '0)},
      '{ActCreate, 32'h8000_0000, 1'b1, mk_grant(StatOk, 4, 5, '0)},
      '{ActCreate, 32'h0000_0001, 1'b1, mk_grant(StatOk, 5, 6, '0)},
      '{ActCreate, 32'h7FFF_FFFF, 1'b1, mk_grant(StatOk, 6, 7, '0)},
      '{ActCreate, 32'hFFFF_FFFE, 1'b1, mk_grant(StatOk, 7, 8, '0)},
      '{ActCreate, 32'h1357_9BDF, 1'b1, mk_grant(StatFull, 0, 0, '0)},
      '{ActYield,  32'hDEAD_BEEF, 1'b1, mk_grant(StatOk, 0, 1, 32'hFFFF_FFFF)},
      '{ActYield,  32'h0000_0000, 1'b0, grant_t'('0)},
      '{ActExit,   32'h2468_ACE0, 1'b0, grant_t'('0)},
      '{ActCreate, 32'hCAFE_F00D, 1'b0, grant_t'('0)},
      '{ActExit,   32'h0F0F_0F0F, 1'b0, grant_t'('0)},
      '{ActExit,   32'hF0F0_F0F0, 1'b0, grant_t'('0)},
      '{ActExit,   32'h3333_3333, 1'b0, grant_t'('0)},
      '{ActExit,   32'hCCCC_CCCC, 1'b0, grant_t'('0)},
      '{ActExit,   32'h5555_5555, 1'b0, grant_t'('0)},
      '{ActExit,   32'hAAAA_AAAA, 1'b0, grant_t'('0)},
      '{ActExit,   32'h6666_6666, 1'b0, grant_t'('0)},
      '{ActExit,   32'h9999_9999, 1'b0, grant_t'('0)},
      '{ActYield,  32'hFFFF_FFFF, 1'b1, mk_grant(StatIdle, 0, 0, '0)}
    };

    for (int k = 0; k < Slots; k++) begin
      slot_tid[k] = '0;
      slot_ptr[k] = '0;
    end
    last_tid      = '0;
    running       = 1'b0;
    run_at        = 0;
    bad_fields    = 0;
    tx_idle_en    = 1'b1;
    rx_idle_en    = 1'b1;
    long_hold_req = 1'b0;
    hold_done     = 1'b0;
    pause_done    = 1'b0;
    create_pct    = 40;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ActCreate;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table
    foreach (rows[i]) begin
      send_request(rows[i].action, rows[i].ctx, rows[i].typed, rows[i].want);
      maybe_gap();
    end

    // Random mix; the create share drifts so the table both fills and drains
    n_done = 0;
    while (n_done < RandItems) begin
      if (n_done % 200 == 0) create_pct = $urandom_range(20, 60);
      if (n_done == 500 && !hold_done) begin
        long_hold_req = 1'b1;
        hold_done     = 1'b1;
      end
      if (n_done == 900 && !pause_done) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (owed_grants.size() != 0);
        pause_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) act = ActUnused;
      else if (pick < 4 + create_pct) act = ActCreate;
      else if (pick < 4 + create_pct + (96 - create_pct) / 2) act = ActYield;
      else act = ActExit;
      case ($urandom_range(0, 9))
        0:       ctx = '0;
        1:       ctx = '1;
        default: ctx = $urandom();
      endcase
      send_request(act, ctx, 1'b0, '0);
      n_done++;
      maybe_gap();
    end

    // Drain the table back to back
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    do send_request(ActExit, $urandom(), 1'b0, '0); while (running);

    // Wait out every owed result, then allow stray ones to show up
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (owed_grants.size() != 0);
    repeat (8) @(posedge clk_i);
    if (bad_fields == 0 && owed_grants.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Result-side pacing: random stalls, one long hold on request
  initial begin
    m_axis_tready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 99) < 25) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
  end

  // Compare each result transfer with the oldest owed grant
  always @(posedge clk_i) begin
    grant_t got;
    grant_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[ResW-1:0];
      if (owed_grants.size() == 0) begin
        bad_fields++;
        $display("%0t ns: result expected none got %h", $time, m_axis_tdata);
      end else begin
        want = owed_grants.pop_front();
        check_field("status", PtrBits'(want.status), PtrBits'(got.status));
        check_field("slot", PtrBits'(want.slot), PtrBits'(got.slot));
        check_field("thread_id", PtrBits'(want.thread_id), PtrBits'(got.thread_id));
        check_field("next_context", want.next_context, got.next_context);
      end
    end
  end

  // Stop a hung run
  initial begin
    #80_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tsrr_pkg.sv
rtl/thread_slot_round_robin_scheduler.sv
verif/tb_thread_slot_round_robin_scheduler.sv
